// ===== rtl/drps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drps_pkg: shared types, constants and calendar helpers
// Packed item and result types, the job handed from front to back, and the
// Gregorian date arithmetic used by both halves of the splitter.
// ----------------------------------------------------------------------------
package drps_pkg;

    localparam int DATE_W  = 23;
    localparam int YEAR_W  = 14;
    localparam int DAY_W   = 9;
    localparam int CDATA_W = 9;

    // configuration register indexes
    localparam logic REG_PERIOD_DAYS = 1'b0;
    localparam logic REG_MAX_PERIODS = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_PERIOD     = 2'd0;
    localparam logic [1:0] STAT_NO_OVERLAP = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW   = 2'd2;

    // modular inverse of 25 mod 2**15 and the largest image of a multiple of 25
    localparam logic [14:0] INV25     = 15'd23593;
    localparam logic [14:0] DIV25_MAX = 15'd1310;

    // days before the start of each month, common year
    localparam logic [8:0] CUM_DAYS [0:11] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [DATE_W-1:0] phase_first;
        logic [DATE_W-1:0] phase_last;
        logic [DATE_W-1:0] request_first;
        logic [DATE_W-1:0] request_last;
    } t_item;

    typedef struct packed {
        logic [13:0] begin_year;
        logic [3:0]  begin_month;
        logic [4:0]  begin_mday;
        logic [13:0] finish_year;
        logic [3:0]  finish_month;
        logic [4:0]  finish_mday;
        logic [5:0]  period_index;
        logic [1:0]  status;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [8:0] period_days;
        logic [5:0] max_periods;
    } t_cfg;

    typedef struct packed {
        logic              no_overlap;
        logic [YEAR_W-1:0] start_year;
        logic [DAY_W-1:0]  start_day;
        logic [YEAR_W-1:0] end_year;
        logic [DAY_W-1:0]  end_day;
    } t_job;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [DAY_W-1:0]  day;
    } t_ydate;

    // year one bit wider so a run can step past the last encodable year
    typedef struct packed {
        logic [YEAR_W:0]  year;
        logic [DAY_W-1:0] day;
    } t_wdate;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] mday;
    } t_md;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_RUN
    } t_back_state;

    function automatic logic f_is_leap(input logic [YEAR_W:0] y);
        logic [YEAR_W:0] prod;
        logic            div25;
        prod  = 15'(y * INV25);
        div25 = (prod <= DIV25_MAX);
        return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
    endfunction

    function automatic logic [DAY_W-1:0] f_year_len(input logic [YEAR_W:0] y);
        return 9'd365 + {8'd0, f_is_leap(y)};
    endfunction

    // clamp the day of year into 1 .. year length
    function automatic t_ydate f_unpack(input logic [DATE_W-1:0] v);
        t_ydate          r;
        logic [DAY_W-1:0] len;
        r.year = v[22:9];
        r.day  = v[8:0];
        len    = f_year_len({1'b0, r.year});
        if (r.day == 9'd0) begin
            r.day = 9'd1;
        end
        if (r.day > len) begin
            r.day = len;
        end
        return r;
    endfunction

    // step a date forward by n days; n below 512 crosses at most two years
    function automatic t_wdate f_advance(input logic [YEAR_W:0] y,
                                         input logic [DAY_W-1:0] d,
                                         input logic [DAY_W-1:0] n);
        t_wdate          r;
        logic [9:0]      dd;
        logic [DAY_W-1:0] len0;
        logic [DAY_W-1:0] len1;
        logic [YEAR_W:0] y1;
        dd   = {1'b0, d} + {1'b0, n};
        y1   = y + 15'd1;
        len0 = f_year_len(y);
        len1 = f_year_len(y1);
        r.year = y;
        if (dd > {1'b0, len0}) begin
            dd     = dd - {1'b0, len0};
            r.year = y1;
            if (dd > {1'b0, len1}) begin
                dd     = dd - {1'b0, len1};
                r.year = y + 15'd2;
            end
        end
        r.day = dd[8:0];
        return r;
    endfunction

    function automatic t_md f_month_day(input logic leap, input logic [DAY_W-1:0] day);
        t_md        md;
        logic [8:0] base;
        logic [8:0] thr;
        md.month = 4'd1;
        base     = 9'd0;
        for (int i = 1; i < 12; i++) begin
            thr = CUM_DAYS[i] + ((i >= 2) ? {8'd0, leap} : 9'd0);
            if (day > thr) begin
                md.month = 4'(i + 1);
                base     = thr;
            end
        end
        md.mday = 5'(day - base);
        return md;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/date_range_period_splitter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// date_range_period_splitter_unit: split an interval overlap into periods
// Intersects a phase and a request interval and emits one beat per period.
// ----------------------------------------------------------------------------
// Usage:
//   Input: pulse start with i_item; the item is taken at an edge where start
//   is high and busy is low. busy stays high while a taken item sits in the
//   front's capture and clamp registers and while the job queue is full.
//   Output: each beat is on o_result for one cycle with o_strobe high; the
//   receiver cannot stall, so every beat must be taken when shown. The final
//   beat of an item has last set.
//   Config: write period_days (index 0) or max_periods (index 1) through
//   i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle.
//   Path: a taken item is registered, clamped, classified and queued; an
//   idle sequencer pops it and registers a no-overlap beat, or primes the
//   first period and then emits one period beat per cycle.
//   Flow: the front takes no new item while the last is still in its
//   registers; the period sequencer pops a run job, primes it and emits
//   its period beats and any overflow beat, and answers a no-overlap job
//   from idle. Classification of later items proceeds meanwhile into a
//   QUEUE_DEPTH-entry job queue.
//   Reset: clears the queue and sequencer and loads period_days 1 and
//   max_periods 63.
// ----------------------------------------------------------------------------
module date_range_period_splitter_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire drps_pkg::t_item              i_item,
    output logic                              o_strobe,
    output drps_pkg::t_result                 o_result,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_idx,
    input  wire logic [drps_pkg::CDATA_W-1:0] i_cfg_data
);
    import drps_pkg::*;

    t_cfg r_cfg;
    logic w_push, w_pop, w_q_valid, w_q_full;
    t_job w_push_job, w_head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_days <= 9'd1;
            r_cfg.max_periods <= 6'd63;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PERIOD_DAYS: r_cfg.period_days <= i_cfg_data;
                REG_MAX_PERIODS: r_cfg.max_periods <= i_cfg_data[5:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    drps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_q_full (w_q_full),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    drps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_job   (w_head_job)
    );

    drps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_job     (w_head_job),
        .o_pop     (w_pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/drps_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drps_front: input capture and interval classification
// Registers an accepted item, clamps the four dates, intersects the two
// intervals and pushes either a no-overlap job or a run job to the queue.
// ----------------------------------------------------------------------------
module drps_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire drps_pkg::t_item i_item,
    input  wire logic            i_q_full,
    output logic                 o_busy,
    output logic                 o_push,
    output drps_pkg::t_job       o_job
);
    import drps_pkg::*;

    logic   r_s1_vld;
    logic   r_s2_vld;
    t_item  r_item;
    t_ydate r_pf, r_pl, r_rf, r_rl;
    logic   w_accept;

    logic [DATE_W-1:0] w_pf_key, w_pl_key, w_rf_key, w_rl_key;
    logic [DATE_W-1:0] w_os_key, w_oe_key;
    t_ydate            w_os, w_oe;

    // one item in flight; the queue has room for it whenever it was accepted
    assign o_busy   = r_s1_vld | r_s2_vld | i_q_full;
    assign w_accept = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        if (r_s1_vld) begin
            r_pf <= f_unpack(r_item.phase_first);
            r_pl <= f_unpack(r_item.phase_last);
            r_rf <= f_unpack(r_item.request_first);
            r_rl <= f_unpack(r_item.request_last);
        end
    end

    always_comb begin
        w_pf_key = {r_pf.year, r_pf.day};
        w_pl_key = {r_pl.year, r_pl.day};
        w_rf_key = {r_rf.year, r_rf.day};
        w_rl_key = {r_rl.year, r_rl.day};
        // overlap runs from the later start to the earlier end
        w_os     = (w_pf_key >= w_rf_key) ? r_pf : r_rf;
        w_oe     = (w_pl_key <= w_rl_key) ? r_pl : r_rl;
        w_os_key = {w_os.year, w_os.day};
        w_oe_key = {w_oe.year, w_oe.day};

        o_push           = r_s2_vld;
        o_job.no_overlap = (w_pl_key <= w_rf_key) || (w_pf_key >= w_rl_key)
                           || (w_os_key > w_oe_key);
        o_job.start_year = w_os.year;
        o_job.start_day  = w_os.day;
        o_job.end_year   = w_oe.year;
        o_job.end_day    = w_oe.day;
    end

endmodule
`default_nettype wire

// ===== rtl/drps_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drps_queue: job queue between classifier and period sequencer
// Small register FIFO; the head entry is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module drps_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire drps_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_valid,
    output logic                o_full,
    output drps_pkg::t_job      o_job
);
    import drps_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job pushed into a full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from an empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count lost a push");

endmodule
`default_nettype wire

// ===== rtl/drps_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drps_back: period sequencer
// Pops a job, walks the overlap one period per cycle and emits each period
// as calendar dates; closes with a no-overlap or overflow beat when needed.
// ----------------------------------------------------------------------------
module drps_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire drps_pkg::t_cfg i_cfg,
    input  wire logic           i_q_valid,
    input  wire drps_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_strobe,
    output drps_pkg::t_result   o_result
);
    import drps_pkg::*;

    t_back_state r_state, n_state;
    logic        r_strobe, n_strobe;
    t_result     r_out, n_out;
    logic [5:0]  r_n, n_n;

    logic [YEAR_W:0]   r_nsy, n_nsy;
    logic [DAY_W-1:0]  r_nsd, n_nsd;
    logic [YEAR_W-1:0] r_oey, n_oey;
    logic [DAY_W-1:0]  r_oed, n_oed;
    logic [YEAR_W-1:0] r_cur_sy, n_cur_sy, r_cur_ey, n_cur_ey;
    logic [DAY_W-1:0]  r_cur_sd, n_cur_sd, r_cur_ed, n_cur_ed;
    logic              r_cur_last, n_cur_last;

    logic [DAY_W-1:0] w_p, w_pm1;
    t_wdate           w_end, w_nxt;
    logic [YEAR_W+DAY_W:0] w_oe_key;
    logic             w_end_over, w_nxt_over;
    t_md              w_bmd, w_fmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_n      <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_n      <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_nsy      <= n_nsy;
        r_nsd      <= n_nsd;
        r_oey      <= n_oey;
        r_oed      <= n_oed;
        r_cur_sy   <= n_cur_sy;
        r_cur_sd   <= n_cur_sd;
        r_cur_ey   <= n_cur_ey;
        r_cur_ed   <= n_cur_ed;
        r_cur_last <= n_cur_last;
    end

    // next period from the pending start: its clamped end and the start after it
    always_comb begin
        w_p        = (i_cfg.period_days == 9'd0) ? 9'd1 : i_cfg.period_days;
        w_pm1      = w_p - 9'd1;
        w_end      = f_advance(r_nsy, r_nsd, w_pm1);
        w_nxt      = f_advance(r_nsy, r_nsd, w_p);
        w_oe_key   = {1'b0, r_oey, r_oed};
        w_end_over = {w_end.year, w_end.day} > w_oe_key;
        w_nxt_over = {w_nxt.year, w_nxt.day} > w_oe_key;
        w_bmd      = f_month_day(f_is_leap({1'b0, r_cur_sy}), r_cur_sd);
        w_fmd      = f_month_day(f_is_leap({1'b0, r_cur_ey}), r_cur_ed);
    end

    always_comb begin
        n_state    = r_state;
        n_strobe   = 1'b0;
        n_out      = r_out;
        n_n        = r_n;
        n_nsy      = r_nsy;
        n_nsd      = r_nsd;
        n_oey      = r_oey;
        n_oed      = r_oed;
        n_cur_sy   = r_cur_sy;
        n_cur_sd   = r_cur_sd;
        n_cur_ey   = r_cur_ey;
        n_cur_ed   = r_cur_ed;
        n_cur_last = r_cur_last;
        o_pop      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_job.no_overlap) begin
                        n_strobe     = 1'b1;
                        n_out        = '0;
                        n_out.status = STAT_NO_OVERLAP;
                        n_out.last   = 1'b1;
                    end else begin
                        n_nsy   = {1'b0, i_job.start_year};
                        n_nsd   = i_job.start_day;
                        n_oey   = i_job.end_year;
                        n_oed   = i_job.end_day;
                        n_n     = '0;
                        n_state = ST_PRIME;
                    end
                end
            end
            ST_PRIME: begin
                n_cur_sy   = r_nsy[YEAR_W-1:0];
                n_cur_sd   = r_nsd;
                n_cur_ey   = w_end_over ? r_oey : w_end.year[YEAR_W-1:0];
                n_cur_ed   = w_end_over ? r_oed : w_end.day;
                n_cur_last = w_nxt_over;
                n_nsy      = w_nxt.year;
                n_nsd      = w_nxt.day;
                n_state    = ST_RUN;
            end
            ST_RUN: begin
                n_strobe = 1'b1;
                if (r_n >= i_cfg.max_periods) begin
                    n_out              = '0;
                    n_out.period_index = r_n;
                    n_out.status       = STAT_OVERFLOW;
                    n_out.last         = 1'b1;
                    n_state            = ST_IDLE;
                end else begin
                    n_out.begin_year   = r_cur_sy;
                    n_out.begin_month  = w_bmd.month;
                    n_out.begin_mday   = w_bmd.mday;
                    n_out.finish_year  = r_cur_ey;
                    n_out.finish_month = w_fmd.month;
                    n_out.finish_mday  = w_fmd.mday;
                    n_out.period_index = r_n;
                    n_out.status       = STAT_PERIOD;
                    n_out.last         = r_cur_last;
                    if (r_cur_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        // advance to the following period
                        n_n        = r_n + 6'd1;
                        n_cur_sy   = r_nsy[YEAR_W-1:0];
                        n_cur_sd   = r_nsd;
                        n_cur_ey   = w_end_over ? r_oey : w_end.year[YEAR_W-1:0];
                        n_cur_ed   = w_end_over ? r_oed : w_end.day;
                        n_cur_last = w_nxt_over;
                        n_nsy      = w_nxt.year;
                        n_nsd      = w_nxt.day;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_n <= i_cfg.max_periods))
        else $error("period count ran past the limit");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.status == STAT_PERIOD) |-> (r_out.period_index < i_cfg.max_periods))
        else $error("period emitted beyond the limit");

    a_close_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.status != STAT_PERIOD)
        |-> (r_out.last && r_out.begin_year == '0 && r_out.finish_year == '0))
        else $error("closing beat carries dates or is not last");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE && i_q_valid))
        else $error("job taken outside idle");

endmodule
`default_nettype wire

// ===== sim/tb_date_range_period_splitter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_date_range_period_splitter_unit: self-checking bench for the splitter
// Drives interval pairs through the command port with random gaps and checks
// every period beat against a calendar predictor held in a small scoreboard.
// Register settings change between phases once all beats have drained.
// ----------------------------------------------------------------------------
module tb_date_range_period_splitter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import drps_pkg::*;

    class period_book;
        int unsigned period_days;
        int unsigned max_periods;
        t_result     expected_periods[$];
        int          failures;
        int          reported;

        function new();
            period_days = 1;
            max_periods = 63;
            failures    = 0;
            reported    = 0;
        endfunction

        function void set_reg(logic idx, int unsigned v);
            if (idx == REG_PERIOD_DAYS) begin
                period_days = v & 32'h1FF;
            end else begin
                max_periods = v & 32'h3F;
            end
        endfunction

        function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned year_len(int unsigned y);
            return 365 + is_leap(y);
        endfunction

        function int unsigned month_days(bit lp, int unsigned m);
            case (m)
                2: return 28 + lp;
                4, 6, 9, 11: return 30;
                default: return 31;
            endcase
        endfunction

        // clamp day of year into 1 .. year length
        function void split_date(logic [22:0] v, output int unsigned y,
                                 output int unsigned d);
            y = v[22:9];
            d = v[8:0];
            if (d < 1) d = 1;
            if (d > year_len(y)) d = year_len(y);
        endfunction

        function void step_days(inout int unsigned y, inout int unsigned d,
                                input int unsigned n);
            d = d + n;
            while (d > year_len(y)) begin
                d = d - year_len(y);
                y++;
            end
        endfunction

        function void month_of(int unsigned y, int unsigned d, output int unsigned m,
                               output int unsigned md);
            bit lp;
            lp = is_leap(y);
            m  = 1;
            while (m < 12 && d > month_days(lp, m)) begin
                d = d - month_days(lp, m);
                m++;
            end
            md = d;
        endfunction

        function t_result make_beat(int unsigned by, int unsigned bm, int unsigned bd,
                                    int unsigned fy, int unsigned fm, int unsigned fd,
                                    int unsigned idx, logic [1:0] st, bit lst);
            t_result r;
            r.begin_year   = 14'(by);
            r.begin_month  = 4'(bm);
            r.begin_mday   = 5'(bd);
            r.finish_year  = 14'(fy);
            r.finish_month = 4'(fm);
            r.finish_mday  = 5'(fd);
            r.period_index = 6'(idx);
            r.status       = st;
            r.last         = lst;
            return r;
        endfunction

        function void note_item(t_item it);
            int unsigned py1, pd1, py2, pd2, ry1, rd1, ry2, rd2;
            int unsigned pf, pl, rf, rl, os, oe;
            int unsigned sy, sd, ey, ed, oey, oed, ny, nd, p, n;
            int unsigned bm, bd, fm, fd;
            bit          done;
            split_date(it.phase_first, py1, pd1);
            split_date(it.phase_last, py2, pd2);
            split_date(it.request_first, ry1, rd1);
            split_date(it.request_last, ry2, rd2);
            pf = py1 * 512 + pd1;
            pl = py2 * 512 + pd2;
            rf = ry1 * 512 + rd1;
            rl = ry2 * 512 + rd2;
            if (pf >= rf) begin os = pf; sy = py1; sd = pd1; end
            else begin os = rf; sy = ry1; sd = rd1; end
            if (pl <= rl) begin oe = pl; oey = py2; oed = pd2; end
            else begin oe = rl; oey = ry2; oed = rd2; end
            // disjoint or reversed overlap: single no-overlap beat
            if (pl <= rf || pf >= rl || os > oe) begin
                expected_periods.push_back(make_beat(0, 0, 0, 0, 0, 0, 0,
                                                     STAT_NO_OVERLAP, 1'b1));
                return;
            end
            p    = (period_days == 0) ? 1 : period_days;
            n    = 0;
            done = 1'b0;
            while (!done) begin
                if (n >= max_periods) begin
                    expected_periods.push_back(make_beat(0, 0, 0, 0, 0, 0, n,
                                                         STAT_OVERFLOW, 1'b1));
                    done = 1'b1;
                end else begin
                    ey = sy;
                    ed = sd;
                    step_days(ey, ed, p - 1);
                    if (ey * 512 + ed > oe) begin
                        ey = oey;
                        ed = oed;
                    end
                    ny = sy;
                    nd = sd;
                    step_days(ny, nd, p);
                    month_of(sy, sd, bm, bd);
                    month_of(ey, ed, fm, fd);
                    expected_periods.push_back(make_beat(sy, bm, bd, ey, fm, fd, n,
                                                         STAT_PERIOD,
                                                         (ny * 512 + nd) > oe));
                    n++;
                    sy   = ny;
                    sd   = nd;
                    done = (sy * 512 + sd) > oe;
                end
            end
        endfunction

        function string beat_text(t_result r);
            return $sformatf("%0d-%0d-%0d..%0d-%0d-%0d idx %0d st %0d last %0b",
                             r.begin_year, r.begin_month, r.begin_mday,
                             r.finish_year, r.finish_month, r.finish_mday,
                             r.period_index, r.status, r.last);
        endfunction

        function void check_beat(t_result got);
            t_result want;
            bit      bad;
            if (expected_periods.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    $display("unexpected beat: %s", beat_text(got));
                    reported++;
                end
                return;
            end
            want = expected_periods.pop_front();
            bad  = (got.begin_year !== want.begin_year) ||
                   (got.begin_month !== want.begin_month) ||
                   (got.begin_mday !== want.begin_mday) ||
                   (got.finish_year !== want.finish_year) ||
                   (got.finish_month !== want.finish_month) ||
                   (got.finish_mday !== want.finish_mday) ||
                   (got.period_index !== want.period_index) ||
                   (got.status !== want.status) ||
                   (got.last !== want.last);
            if (bad) begin
                failures++;
                if (reported < 10) begin
                    $display("beat mismatch at %0t: expected %s, got %s",
                             $realtime, beat_text(want), beat_text(got));
                    reported++;
                end
            end
        endfunction

        function int pending();
            return expected_periods.size();
        endfunction

        function void flush_leftover();
            if (expected_periods.size() != 0) begin
                failures += expected_periods.size();
                $display("%0d expected beats never arrived", expected_periods.size());
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_item                i_item     = '0;
    logic                 o_strobe;
    t_result              o_result;
    logic                 i_cfg_we   = 1'b0;
    logic                 i_cfg_idx  = REG_PERIOD_DAYS;
    logic [CDATA_W-1:0]   i_cfg_data = '0;

    period_book sb;
    int         burst_left = 0;

    date_range_period_splitter_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_beat(o_result);
        end
    end

    function automatic logic [22:0] pk(int unsigned y, int unsigned d);
        return {14'(y), 9'(d)};
    endfunction

    function automatic t_item mk(logic [22:0] pf, logic [22:0] pl,
                                 logic [22:0] rf, logic [22:0] rl);
        t_item it;
        it.phase_first   = pf;
        it.phase_last    = pl;
        it.request_first = rf;
        it.request_last  = rl;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item       it;
        int unsigned kind, y0, d0, y1, d1, y2, d2, y3, d3;
        int unsigned p, len, a, b;
        logic [22:0] lo_first, lo_last, hi_first, hi_last, tmp;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: y0 = $urandom_range(0, 16383);
            1: y0 = $urandom_range(1890, 2110);
            2: y0 = $urandom_range(0, 8);
            default: y0 = $urandom_range(16370, 16383);
        endcase
        d0 = $urandom_range(1, sb.year_len(y0));
        if (kind < 70) begin
            // overlapping pair sized around the period and limit settings
            p   = (sb.period_days == 0) ? 1 : sb.period_days;
            len = $urandom_range(0, sb.max_periods + 1) * p + $urandom_range(0, p - 1);
            a   = $urandom_range(0, 30);
            b   = $urandom_range(0, 30);
            y1 = y0; d1 = d0;
            sb.step_days(y1, d1, a);
            y2 = y1; d2 = d1;
            sb.step_days(y2, d2, len);
            y3 = y2; d3 = d2;
            sb.step_days(y3, d3, b);
            if ($urandom_range(0, 1)) begin
                it.phase_first   = pk(y0, d0);
                it.request_first = pk(y1, d1);
            end else begin
                it.request_first = pk(y0, d0);
                it.phase_first   = pk(y1, d1);
            end
            if ($urandom_range(0, 1)) begin
                it.phase_last   = pk(y2, d2);
                it.request_last = pk(y3, d3);
            end else begin
                it.request_last = pk(y2, d2);
                it.phase_last   = pk(y3, d3);
            end
        end else if (kind < 85) begin
            // disjoint, touching or reversed intervals
            y1 = y0; d1 = d0;
            sb.step_days(y1, d1, $urandom_range(0, 40));
            y2 = y1; d2 = d1;
            sb.step_days(y2, d2, $urandom_range(0, 3));
            y3 = y2; d3 = d2;
            sb.step_days(y3, d3, $urandom_range(0, 40));
            lo_first = pk(y0, d0);
            lo_last  = pk(y1, d1);
            hi_first = pk(y2, d2);
            hi_last  = pk(y3, d3);
            if ($urandom_range(0, 2) == 0) begin
                tmp      = lo_first;
                lo_first = hi_first;
                hi_first = tmp;
            end
            if ($urandom_range(0, 1)) begin
                it = mk(lo_first, lo_last, hi_first, hi_last);
            end else begin
                it = mk(hi_first, hi_last, lo_first, lo_last);
            end
        end else begin
            it = mk(23'($urandom()), 23'($urandom()), 23'($urandom()), 23'($urandom()));
        end
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit hold);
        int gap;
        gap = $urandom_range(0, 12);
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(8, 30);
        end
        // hold off until the block has delivered every pending beat
        if (hold || $urandom_range(0, 39) == 0) begin
            start <= 1'b0;
            do @(negedge i_clk); while (sb.pending() != 0);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic idx, input int unsigned v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CDATA_W'(v);
        sb.set_reg(idx, v);
        @(negedge i_clk);
    endtask

    task automatic set_config(input int unsigned pd, input int unsigned mp);
        drain();
        write_reg(REG_PERIOD_DAYS, pd);
        write_reg(REG_MAX_PERIODS, mp);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned pd_list [8];
        int unsigned mp_list [8];
        sb = new();
        pd_list = '{1, 365, 511, 7, 30, 0, 0, 2};
        mp_list = '{63, 63, 1, 10, 63, 0, 5, 0};
        pd_list[5] = $urandom_range(1, 365);
        mp_list[5] = $urandom_range(1, 63);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: one-day periods, limit 63
        send_item(mk(pk(2000, 10), pk(2000, 20), pk(2000, 15), pk(2000, 40)), 1'b0);
        send_item(mk(pk(2000, 1), pk(2000, 5), pk(2000, 10), pk(2000, 20)), 1'b0);
        send_item(mk(pk(2000, 1), pk(2000, 10), pk(2000, 10), pk(2000, 20)), 1'b0);
        send_item(mk(pk(2001, 1), pk(2001, 9), pk(2000, 1), pk(2001, 1)), 1'b0);
        send_item(mk(pk(2000, 30), pk(2000, 20), pk(2000, 10), pk(2000, 40)), 1'b0);
        send_item(mk(pk(1900, 0), pk(1900, 400), pk(1899, 360), pk(1900, 3)), 1'b0);
        send_item(mk(pk(0, 360), pk(1, 5), pk(0, 300), pk(0, 511)), 1'b0);
        send_item(mk('1, '1, '1, '1), 1'b0);
        send_item(mk('0, '0, '0, '0), 1'b0);
        send_item(mk(pk(2000, 58), pk(2000, 62), pk(1999, 1), pk(2001, 1)), 1'b1);
        send_item(mk(pk(2020, 1), pk(2021, 1), pk(2019, 1), pk(2022, 1)), 1'b0);
        send_item(mk(pk(2020, 300), pk(2020, 366), pk(2020, 1), pk(2021, 60)), 1'b0);

        // zero period and zero limit: an overlapping item overflows at once
        set_config(0, 0);
        send_item(mk(pk(2020, 1), pk(2021, 1), pk(2019, 1), pk(2022, 1)), 1'b0);
        send_item(mk(pk(2000, 1), pk(2000, 5), pk(2000, 10), pk(2000, 20)), 1'b0);
        set_config(0, 63);
        send_item(mk(pk(2000, 10), pk(2000, 20), pk(2000, 15), pk(2000, 40)), 1'b0);

        // longest period, crossing years up to the top encodable year
        set_config(511, 3);
        send_item(mk(pk(16382, 100), pk(16383, 365), pk(16382, 1), pk(16383, 511)), 1'b0);
        send_item(mk(pk(2000, 1), pk(2010, 1), pk(1999, 1), pk(2011, 1)), 1'b0);
        send_item(mk(pk(16383, 300), pk(16383, 511), pk(16383, 1), pk(16383, 400)), 1'b0);
        set_config(365, 63);
        send_item(mk(pk(1896, 1), pk(1905, 1), pk(1896, 1), pk(1905, 1)), 1'b0);
        send_item(mk(pk(1999, 200), pk(2001, 100), pk(1999, 1), pk(2003, 1)), 1'b0);

        for (int ph = 0; ph < 8; ph++) begin
            set_config(pd_list[ph], mp_list[ph]);
            for (int k = 0; k < 49; k++) begin
                send_item(random_item(), 1'b0);
            end
        end

        start <= 1'b0;
        for (int w = 0; w < 20000 && sb.pending() != 0; w++) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        sb.flush_leftover();
        if (sb.failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire
